>>> design/rmco_pkg.sv
// ----------------------------------------------------------------------------
// rmco_pkg
// Shared types and constants for the rover motion command and odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmco_pkg;

    // Event codes carried on the input tuser
    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_FORWARD = 3'd1,
        FUNC_REVERSE = 3'd2,
        FUNC_RIGHT   = 3'd3,
        FUNC_LEFT    = 3'd4,
        FUNC_STOP    = 3'd5,
        FUNC_SPEED   = 3'd6,
        FUNC_ENCODER = 3'd7
    } t_func;

    // Operation code meaning no operation
    localparam logic [2:0] OP_NONE = 3'd0;

    // Configuration register indexes
    localparam logic CFG_OP_DURATION = 1'b0;
    localparam logic CFG_STOP_SPEED  = 1'b1;

    // Widths
    localparam int FUNC_W  = 3;
    localparam int SPEED_W = 7;
    localparam int CNT_W   = 8;
    localparam int ACC_W   = 16;
    localparam int TOT_W   = 16;
    localparam int TICK_W  = 32;
    localparam int DUR_W   = 16;
    localparam int PHASE_W = 4;
    localparam int NUM_TOT = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;

    // Reset values
    localparam logic [DUR_W-1:0]   DUR_AT_RESET   = 16'd65535;
    localparam logic [SPEED_W-1:0] STOP_AT_RESET  = 7'd64;
    localparam logic [SPEED_W-1:0] SPEED_AT_RESET = 7'd34;

    // Odometry update every tenth tick
    localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd9;

    // Reciprocal multiply: avg / 19 and avg / 7, exact for 16-bit avg
    localparam int              MULT_W        = 17;
    localparam logic [MULT_W-1:0] DIV_CM_MULT  = 17'd55189;
    localparam int              DIV_CM_SHIFT  = 20;
    localparam logic [MULT_W-1:0] DIV_DEG_MULT = 17'd74899;
    localparam int              DIV_DEG_SHIFT = 19;

    // Odometry update request from the divider
    typedef struct packed {
        logic             en;
        logic [1:0]       idx;
        logic [TOT_W-1:0] inc;
    } t_odo_upd;

endpackage

`default_nettype wire

>>> design/rmco_odo_calc.sv
// ----------------------------------------------------------------------------
// rmco_odo_calc
// Averages the encoder accumulators and scales them to centimeters or
// degrees for the most recent operation, using one reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module rmco_odo_calc (
    input  wire logic [rmco_pkg::ACC_W-1:0] i_left_acc,
    input  wire logic [rmco_pkg::ACC_W-1:0] i_right_acc,
    input  wire logic [2:0]                 i_recent_op,
    output rmco_pkg::t_odo_upd              o_upd
);
    import rmco_pkg::*;

    logic [ACC_W:0]          w_sum;
    logic [ACC_W-1:0]        w_avg;
    logic                    w_is_dist;
    logic [MULT_W-1:0]       w_mult;
    logic [ACC_W+MULT_W-1:0] w_prod;
    logic [ACC_W+MULT_W-1:0] w_quot;
    logic                    w_is_motion;

    // Average of both wheels
    assign w_sum = {1'b0, i_left_acc} + {1'b0, i_right_acc};
    assign w_avg = w_sum[ACC_W:1];

    // Forward and reverse count distance, turns count degrees
    assign w_is_dist = (i_recent_op == FUNC_FORWARD) || (i_recent_op == FUNC_REVERSE);
    assign w_mult    = w_is_dist ? DIV_CM_MULT : DIV_DEG_MULT;
    assign w_prod    = {{MULT_W{1'b0}}, w_avg} * {{ACC_W{1'b0}}, w_mult};
    assign w_quot    = w_is_dist ? (w_prod >> DIV_CM_SHIFT) : (w_prod >> DIV_DEG_SHIFT);

    assign w_is_motion = (i_recent_op == FUNC_FORWARD) || (i_recent_op == FUNC_REVERSE) ||
                         (i_recent_op == FUNC_RIGHT)   || (i_recent_op == FUNC_LEFT);

    // Totals are ordered forward, reverse, right, left
    always_comb begin
        o_upd.en  = w_is_motion;
        o_upd.idx = 2'(i_recent_op - 3'd1);
        o_upd.inc = w_quot[TOT_W-1:0];
    end

endmodule

`default_nettype wire

>>> design/rover_motion_command_odometer.sv
// ----------------------------------------------------------------------------
// rover_motion_command_odometer
// Rover motion command decoder with tick timeout and encoder odometry.
// ----------------------------------------------------------------------------
// Takes one event per clock cycle while the result stream keeps up. An
// accepted event sits in an input register, is applied to the rover state in
// a single pass when the output register is free, and its result lands in
// the output register. The whole state update (tick timeout compare, encoder
// average and reciprocal multiply into the totals) is combinational between
// the input register and the state registers, which is what sets the rate of
// one event per cycle; the output register lets the next event enter while a
// result still waits to be taken. Configuration registers are written with
// i_cfg_we and apply to events processed after.
// ----------------------------------------------------------------------------
`default_nettype none

module rover_motion_command_odometer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Event stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: speed_value[6:0], left_count[14:7], right_count[22:15], zero pad
    input  wire logic [rmco_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: func[2:0]
    input  wire logic [rmco_pkg::FUNC_W-1:0]     i_s_axis_tuser,
    // Result stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: right_drive_byte[7:0], left_drive_byte[14:8], forward_cm[30:15],
    //        reverse_cm[46:31], right_deg[62:47], left_deg[78:63], zero pad
    output logic [rmco_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: drive_valid[0]
    output logic                                 o_m_axis_tuser,
    // Configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_addr,
    input  wire logic [rmco_pkg::DUR_W-1:0]      i_cfg_wdata
);
    import rmco_pkg::*;

    // Configuration
    logic [DUR_W-1:0]   r_op_duration;
    logic [SPEED_W-1:0] r_stop_speed;

    // Input register
    logic               r_in_valid;
    logic [FUNC_W-1:0]  r_in_func;
    logic [SPEED_W-1:0] r_in_speed;
    logic [CNT_W-1:0]   r_in_lcnt;
    logic [CNT_W-1:0]   r_in_rcnt;

    // Output register
    logic               r_out_valid;
    logic               r_out_drive;
    logic [SPEED_W-1:0] r_out_code;

    // Rover state
    logic [2:0]         r_active_op,  n_active_op;
    logic [2:0]         r_recent_op,  n_recent_op;
    logic [TICK_W-1:0]  r_tick_count, n_tick_count;
    logic [PHASE_W-1:0] r_phase,      n_phase;
    logic [ACC_W-1:0]   r_left_acc,   n_left_acc;
    logic [ACC_W-1:0]   r_right_acc,  n_right_acc;
    logic [SPEED_W-1:0] r_speed,      n_speed;
    logic [TOT_W-1:0]   r_tot [NUM_TOT];
    logic [TOT_W-1:0]   n_tot [NUM_TOT];
    logic               n_drive;
    logic [SPEED_W-1:0] n_code;

    logic               w_advance;
    logic [TICK_W-1:0]  w_tick_inc;
    logic               w_timeout;
    logic               w_do_update;
    logic [ACC_W:0]     w_lsum;
    logic [ACC_W:0]     w_rsum;
    t_odo_upd           w_upd;

    // Move the held event into the output register when that is free
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    // Configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_duration <= DUR_AT_RESET;
            r_stop_speed  <= STOP_AT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OP_DURATION: r_op_duration <= i_cfg_wdata;
                CFG_STOP_SPEED:  r_stop_speed  <= i_cfg_wdata[SPEED_W-1:0];
                default:         r_op_duration <= r_op_duration;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_func  <= i_s_axis_tuser;
            r_in_speed <= i_s_axis_tdata[6:0];
            r_in_lcnt  <= i_s_axis_tdata[14:7];
            r_in_rcnt  <= i_s_axis_tdata[22:15];
        end
    end

    // Odometry scaling of the current accumulators
    rmco_odo_calc u_odo_calc (
        .i_left_acc  (r_left_acc),
        .i_right_acc (r_right_acc),
        .i_recent_op (r_recent_op),
        .o_upd       (w_upd)
    );

    assign w_tick_inc = r_tick_count + TICK_W'(1);
    assign w_timeout  = (r_active_op != OP_NONE) &&
                        (w_tick_inc >= {{(TICK_W-DUR_W){1'b0}}, r_op_duration});
    assign w_lsum     = {1'b0, r_left_acc} + {{(ACC_W-CNT_W+1){1'b0}}, r_in_lcnt};
    assign w_rsum     = {1'b0, r_right_acc} + {{(ACC_W-CNT_W+1){1'b0}}, r_in_rcnt};

    // Apply one event to the state
    always_comb begin
        n_active_op  = r_active_op;
        n_recent_op  = r_recent_op;
        n_tick_count = r_tick_count;
        n_phase      = r_phase;
        n_left_acc   = r_left_acc;
        n_right_acc  = r_right_acc;
        n_speed      = r_speed;
        n_drive      = 1'b0;
        n_code       = '0;
        w_do_update  = 1'b0;
        case (t_func'(r_in_func))
            FUNC_TICK: begin
                if (w_timeout) begin
                    n_drive      = 1'b1;
                    n_code       = r_stop_speed;
                    n_active_op  = OP_NONE;
                    n_tick_count = '0;
                    n_phase      = '0;
                end else begin
                    n_tick_count = w_tick_inc;
                    // Track the count modulo ten; a wrap of the count lands on zero
                    if (w_tick_inc == '0 || r_phase == PHASE_LAST) begin
                        n_phase = '0;
                    end else begin
                        n_phase = r_phase + PHASE_W'(1);
                    end
                end
                w_do_update = (n_phase == '0);
                if (w_do_update) begin
                    n_left_acc  = '0;
                    n_right_acc = '0;
                end
            end
            FUNC_FORWARD, FUNC_REVERSE, FUNC_RIGHT, FUNC_LEFT: begin
                n_active_op  = r_in_func;
                n_recent_op  = r_in_func;
                n_tick_count = '0;
                n_phase      = '0;
                n_left_acc   = '0;
                n_right_acc  = '0;
                n_drive      = 1'b1;
                n_code       = r_speed;
            end
            FUNC_STOP: begin
                n_active_op  = OP_NONE;
                n_tick_count = '0;
                n_phase      = '0;
                n_drive      = 1'b1;
                n_code       = r_stop_speed;
            end
            FUNC_SPEED: begin
                n_speed = r_in_speed;
            end
            FUNC_ENCODER: begin
                // Saturate the accumulators
                n_left_acc  = w_lsum[ACC_W] ? '1 : w_lsum[ACC_W-1:0];
                n_right_acc = w_rsum[ACC_W] ? '1 : w_rsum[ACC_W-1:0];
            end
            default: begin
                n_speed = r_speed;
            end
        endcase
        // Add the scaled distance to the total of the recent operation
        for (int k = 0; k < NUM_TOT; k++) begin
            n_tot[k] = r_tot[k];
            if (w_do_update && w_upd.en && w_upd.idx == 2'(k)) begin
                n_tot[k] = r_tot[k] + w_upd.inc;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_op  <= OP_NONE;
            r_recent_op  <= OP_NONE;
            r_tick_count <= '0;
            r_phase      <= '0;
            r_left_acc   <= '0;
            r_right_acc  <= '0;
            r_speed      <= SPEED_AT_RESET;
            for (int k = 0; k < NUM_TOT; k++) begin
                r_tot[k] <= '0;
            end
        end else if (w_advance) begin
            r_active_op  <= n_active_op;
            r_recent_op  <= n_recent_op;
            r_tick_count <= n_tick_count;
            r_phase      <= n_phase;
            r_left_acc   <= n_left_acc;
            r_right_acc  <= n_right_acc;
            r_speed      <= n_speed;
            for (int k = 0; k < NUM_TOT; k++) begin
                r_tot[k] <= n_tot[k];
            end
        end
    end

    // Output register; totals change only when a new result loads, so the
    // state totals double as the result totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_drive <= n_drive;
            r_out_code  <= n_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_drive;
    assign o_m_axis_tdata  = {1'b0, r_tot[3], r_tot[2], r_tot[1], r_tot[0],
                              r_out_code, (r_out_drive ? {1'b1, r_out_code} : 8'd0)} &
                             {{(OUT_DATA_W-15){1'b1}}, {SPEED_W{r_out_drive}}, 8'hFF};

    // Checks
    a_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick_count == '0) |-> (r_phase == '0))
        else $error("tick phase not zero with tick count zero");

    a_active_recent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active_op != OP_NONE) |-> (r_recent_op == r_active_op))
        else $error("active operation differs from recent operation");

    a_motion_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_func >= FUNC_FORWARD && r_in_func <= FUNC_LEFT) |=>
        (r_tick_count == '0 && r_left_acc == '0 && r_right_acc == '0))
        else $error("motion command did not clear counters");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled with free output register");

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_drive) |-> (o_m_axis_tdata[14:0] == 15'd0))
        else $error("drive bytes nonzero without drive");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the rover motion command and odometry block.
// ----------------------------------------------------------------------------
// Sends rover events over the input stream and checks every drive report that
// comes back against a cycle-free model of the rover state kept in this file.
// A short table covers reset values, each event kind, speed extremes, the
// zero-duration stop and the tick with no motion ever run. Random phases then
// follow with different duration and stop-code settings and idle patterns on
// both streams, plus one long encoder burst that drives the accumulators into
// saturation. Mismatches, reports with nothing expected and a stalled bus
// fail the run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmco_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int UPDATE_TICKS   = 10;
    localparam int CM_COUNTS      = 19;
    localparam int DEG_COUNTS     = 7;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 145;
    localparam int BURST_ITEMS    = 280;
    localparam logic [7:0] RIGHT_OFFSET = 8'd128;

    // Slots of the odometry totals
    localparam int TOT_FORWARD = 0;
    localparam int TOT_REVERSE = 1;
    localparam int TOT_RIGHT   = 2;
    localparam int TOT_LEFT    = 3;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;

    // One drive report as carried on the result stream
    typedef struct packed {
        logic               drive;
        logic [7:0]         right_byte;
        logic [SPEED_W-1:0] left_byte;
        logic [TOT_W-1:0]   fwd_cm;
        logic [TOT_W-1:0]   rev_cm;
        logic [TOT_W-1:0]   right_deg;
        logic [TOT_W-1:0]   left_deg;
    } t_drive_report;

    // One row of the directed table: a register write or an event
    typedef struct packed {
        logic               is_write;
        logic               addr;
        logic [DUR_W-1:0]   wdata;
        t_func              func;
        logic [SPEED_W-1:0] speed;
        logic [CNT_W-1:0]   left_cnt;
        logic [CNT_W-1:0]   right_cnt;
        logic               typed;
        t_drive_report      want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [FUNC_W-1:0]     i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  i_cfg_we;
    logic                  i_cfg_addr;
    logic [DUR_W-1:0]      i_cfg_wdata;

    // Rover state as predicted by the testbench
    logic [DUR_W-1:0]   duration_cfg;
    logic [SPEED_W-1:0] stop_code_cfg;
    logic [2:0]         cur_motion;
    logic [2:0]         last_motion;
    logic [TICK_W-1:0]  tick_cnt;
    logic [ACC_W-1:0]   enc_left;
    logic [ACC_W-1:0]   enc_right;
    logic [SPEED_W-1:0] speed_code;
    logic [TOT_W-1:0]   odo_total [NUM_TOT];

    t_drive_report report_q[$];

    int mismatches     = 0;
    int reports_seen   = 0;
    int items_sent     = 0;
    int stall_cycles   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    rover_motion_command_odometer i_dut (.*);

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Apply one event to the predicted rover state and return its report
    function automatic t_drive_report advance_rover(input t_func func,
                                                    input logic [SPEED_W-1:0] speed,
                                                    input logic [CNT_W-1:0] lcnt,
                                                    input logic [CNT_W-1:0] rcnt);
        t_drive_report      rep;
        logic               drive;
        logic [SPEED_W-1:0] code;
        logic [ACC_W:0]     sum;
        logic [ACC_W-1:0]   avg;
        logic [TOT_W-1:0]   inc;
        drive = 1'b0;
        code  = '0;
        case (func)
            FUNC_TICK: begin
                tick_cnt = tick_cnt + 32'd1;
                // stop a running motion once its duration is used up
                if (cur_motion != OP_NONE && tick_cnt >= {16'd0, duration_cfg}) begin
                    drive      = 1'b1;
                    code       = stop_code_cfg;
                    cur_motion = OP_NONE;
                    tick_cnt   = '0;
                end
                // fold the averaged encoder count into the last motion's total
                if (tick_cnt % UPDATE_TICKS == 0) begin
                    if (last_motion != OP_NONE) begin
                        sum = {1'b0, enc_left} + {1'b0, enc_right};
                        avg = sum[ACC_W:1];
                        if (last_motion == FUNC_FORWARD || last_motion == FUNC_REVERSE)
                            inc = TOT_W'(avg / CM_COUNTS);
                        else
                            inc = TOT_W'(avg / DEG_COUNTS);
                        odo_total[last_motion - 3'd1] = odo_total[last_motion - 3'd1] + inc;
                    end
                    enc_left  = '0;
                    enc_right = '0;
                end
            end
            FUNC_FORWARD, FUNC_REVERSE, FUNC_RIGHT, FUNC_LEFT: begin
                cur_motion  = func;
                last_motion = func;
                tick_cnt    = '0;
                enc_left    = '0;
                enc_right   = '0;
                drive       = 1'b1;
                code        = speed_code;
            end
            FUNC_STOP: begin
                cur_motion = OP_NONE;
                tick_cnt   = '0;
                drive      = 1'b1;
                code       = stop_code_cfg;
            end
            FUNC_SPEED: begin
                speed_code = speed;
            end
            FUNC_ENCODER: begin
                // saturate both accumulators
                sum       = {1'b0, enc_right} + {9'd0, rcnt};
                enc_right = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                sum       = {1'b0, enc_left} + {9'd0, lcnt};
                enc_left  = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            end
            default: begin
            end
        endcase
        rep.drive      = drive;
        rep.right_byte = drive ? {1'b0, code} + RIGHT_OFFSET : 8'd0;
        rep.left_byte  = drive ? code : '0;
        rep.fwd_cm     = odo_total[TOT_FORWARD];
        rep.rev_cm     = odo_total[TOT_REVERSE];
        rep.right_deg  = odo_total[TOT_RIGHT];
        rep.left_deg   = odo_total[TOT_LEFT];
        return rep;
    endfunction

    function automatic t_plan_row event_row(input t_func func, input logic [SPEED_W-1:0] speed,
                                            input logic [CNT_W-1:0] lcnt,
                                            input logic [CNT_W-1:0] rcnt);
        t_plan_row row;
        row           = '0;
        row.func      = func;
        row.speed     = speed;
        row.left_cnt  = lcnt;
        row.right_cnt = rcnt;
        return row;
    endfunction

    // Event row whose report is known up front; only the forward total moves
    function automatic t_plan_row checked_row(input t_func func, input logic [SPEED_W-1:0] speed,
                                              input logic [CNT_W-1:0] lcnt,
                                              input logic [CNT_W-1:0] rcnt,
                                              input logic drive, input logic [7:0] rbyte,
                                              input logic [SPEED_W-1:0] lbyte,
                                              input logic [TOT_W-1:0] fwd);
        t_plan_row row;
        row                 = event_row(func, speed, lcnt, rcnt);
        row.typed           = 1'b1;
        row.want.drive      = drive;
        row.want.right_byte = rbyte;
        row.want.left_byte  = lbyte;
        row.want.fwd_cm     = fwd;
        return row;
    endfunction

    function automatic t_plan_row write_row(input logic addr, input logic [DUR_W-1:0] value);
        t_plan_row row;
        row          = '0;
        row.is_write = 1'b1;
        row.addr     = addr;
        row.wdata    = value;
        return row;
    endfunction

    // Offer one event, hold it until the transfer, then queue its expected report
    task automatic send_event(input t_func func, input logic [SPEED_W-1:0] speed,
                              input logic [CNT_W-1:0] lcnt, input logic [CNT_W-1:0] rcnt,
                              input logic typed, input t_drive_report want);
        t_drive_report rep;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, rcnt, lcnt, speed};
        i_s_axis_tuser  <= func;
        do begin
            @(posedge i_clk);
        end while (!(i_s_axis_tvalid && o_s_axis_tready));
        rep = advance_rover(func, speed, lcnt, rcnt);
        report_q.push_back(typed ? want : rep);
        items_sent++;
    endtask

    // Drop valid and hold until every queued report has come back
    task automatic drain_reports();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (report_q.size() != 0);
    endtask

    task automatic write_register(input logic addr, input logic [DUR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_OP_DURATION)
            duration_cfg = value;
        else
            stop_code_cfg = value[SPEED_W-1:0];
    endtask

    // Stall the result stream at random
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Check each report transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_drive_report got;
        t_drive_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.drive      = o_m_axis_tuser;
            got.right_byte = o_m_axis_tdata[7:0];
            got.left_byte  = o_m_axis_tdata[14:8];
            got.fwd_cm     = o_m_axis_tdata[30:15];
            got.rev_cm     = o_m_axis_tdata[46:31];
            got.right_deg  = o_m_axis_tdata[62:47];
            got.left_deg   = o_m_axis_tdata[78:63];
            reports_seen++;
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("report %0d arrived with nothing expected", reports_seen);
            end else begin
                want = report_q.pop_front();
                if (got.drive !== want.drive || got.right_byte !== want.right_byte ||
                    got.left_byte !== want.left_byte || got.fwd_cm !== want.fwd_cm ||
                    got.rev_cm !== want.rev_cm || got.right_deg !== want.right_deg ||
                    got.left_deg !== want.left_deg) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $write("report %0d expected: drive=%0d r=%0d l=%0d",
                               reports_seen, want.drive, want.right_byte, want.left_byte);
                        $display(" fwd=%0d rev=%0d rdeg=%0d ldeg=%0d",
                                 want.fwd_cm, want.rev_cm, want.right_deg, want.left_deg);
                        $write("report %0d actual:   drive=%0d r=%0d l=%0d",
                               reports_seen, got.drive, got.right_byte, got.left_byte);
                        $display(" fwd=%0d rev=%0d rdeg=%0d ldeg=%0d",
                                 got.fwd_cm, got.rev_cm, got.right_deg, got.left_deg);
                    end
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_plan_row        plan[$];
        t_func            func;
        t_idle_mode       mode;
        int               roll;
        int               p;
        int               n;
        int               directed_items;
        logic [DUR_W-1:0] dur;
        logic [DUR_W-1:0] stop_val;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= CFG_OP_DURATION;
        i_cfg_wdata     <= '0;

        // Predicted state after reset
        duration_cfg  = DUR_AT_RESET;
        stop_code_cfg = STOP_AT_RESET;
        cur_motion    = OP_NONE;
        last_motion   = OP_NONE;
        tick_cnt      = '0;
        enc_left      = '0;
        enc_right     = '0;
        speed_code    = SPEED_AT_RESET;
        foreach (odo_total[i])
            odo_total[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset values, every event kind, speed and stop extremes
        plan.push_back(checked_row(FUNC_TICK, 7'd0, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_ENCODER, 7'd0, 8'd255, 8'd255, 1'b0, 8'd0, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_ENCODER, 7'd127, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0, 16'd0));
        // tenth tick with no motion ever run only clears the accumulators
        repeat (9)
            plan.push_back(checked_row(FUNC_TICK, 7'd0, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_FORWARD, 7'd0, 8'd0, 8'd0, 1'b1, 8'd162, 7'd34, 16'd0));
        plan.push_back(checked_row(FUNC_STOP, 7'd0, 8'd0, 8'd0, 1'b1, 8'd192, 7'd64, 16'd0));
        plan.push_back(checked_row(FUNC_SPEED, 7'd127, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_REVERSE, 7'd0, 8'd0, 8'd0, 1'b1, 8'd255, 7'd127, 16'd0));
        plan.push_back(checked_row(FUNC_SPEED, 7'd0, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_RIGHT, 7'd0, 8'd0, 8'd0, 1'b1, 8'd128, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_LEFT, 7'd0, 8'd0, 8'd0, 1'b1, 8'd128, 7'd0, 16'd0));
        // zero duration: the next tick stops the motion and folds the encoders in
        plan.push_back(write_row(CFG_OP_DURATION, 16'd0));
        plan.push_back(write_row(CFG_STOP_SPEED, 16'd127));
        plan.push_back(checked_row(FUNC_FORWARD, 7'd0, 8'd0, 8'd0, 1'b1, 8'd128, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_ENCODER, 7'd0, 8'd200, 8'd100, 1'b0, 8'd0, 7'd0, 16'd0));
        plan.push_back(checked_row(FUNC_TICK, 7'd0, 8'd0, 8'd0, 1'b1, 8'd255, 7'd127, 16'd7));
        plan.push_back(write_row(CFG_OP_DURATION, 16'd65535));
        plan.push_back(write_row(CFG_STOP_SPEED, 16'd0));
        plan.push_back(event_row(FUNC_RIGHT, 7'd85, 8'd170, 8'd85));
        plan.push_back(checked_row(FUNC_STOP, 7'd0, 8'd0, 8'd0, 1'b1, 8'd128, 7'd0, 16'd7));

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain_reports();
                write_register(plan[i].addr, plan[i].wdata);
            end else begin
                send_event(plan[i].func, plan[i].speed, plan[i].left_cnt, plan[i].right_cnt,
                           plan[i].typed, plan[i].want);
            end
        end
        directed_items = items_sent;

        // Random phases, each with its own register settings and idle pattern
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_reports();
            case (p)
                0: dur = 16'd0;
                1: dur = 16'd1;
                2: dur = 16'($urandom_range(2, 30));
                3: dur = 16'd65535;
                4: dur = 16'($urandom_range(0, 65535));
                5: dur = 16'($urandom_range(5, 15));
                6: dur = 16'($urandom_range(0, 40));
                default: dur = 16'd12;
            endcase
            case (p)
                0: stop_val = 16'd127;
                1: stop_val = 16'd0;
                default: stop_val = 16'($urandom_range(0, 65535));
            endcase
            write_register(CFG_OP_DURATION, dur);
            write_register(CFG_STOP_SPEED, stop_val);

            mode           = t_idle_mode'(p % 4);
            src_idle_pct   = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 30 : 0;
            sink_stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 30 : 0;

            // one motion with a long run of near-full encoder counts to saturate
            if (p == 3) begin
                send_event(t_func'(3'($urandom_range(FUNC_FORWARD, FUNC_LEFT))),
                           7'($urandom_range(0, 127)), 8'd0, 8'd0, 1'b0, '0);
                repeat (BURST_ITEMS)
                    send_event(FUNC_ENCODER, 7'($urandom_range(0, 127)),
                               8'($urandom_range(235, 255)), 8'($urandom_range(235, 255)),
                               1'b0, '0);
                repeat (UPDATE_TICKS)
                    send_event(FUNC_TICK, 7'($urandom_range(0, 127)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               1'b0, '0);
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // now and then hold off until the block has emptied
                if ($urandom_range(0, 99) == 0)
                    drain_reports();
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    func = t_func'(3'($urandom_range(FUNC_FORWARD, FUNC_LEFT)));
                else if (roll < 6)
                    func = FUNC_STOP;
                else if (roll < 11)
                    func = FUNC_SPEED;
                else if (roll < 16)
                    func = t_func'(3'($urandom_range(0, 7)));
                else if (roll < 56)
                    func = FUNC_ENCODER;
                else
                    func = FUNC_TICK;
                send_event(func, 7'($urandom_range(0, 127)),
                           $urandom_range(0, 1) ? 8'($urandom_range(180, 255))
                                                : 8'($urandom_range(0, 255)),
                           $urandom_range(0, 1) ? 8'($urandom_range(180, 255))
                                                : 8'($urandom_range(0, 255)),
                           1'b0, '0);
            end
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (report_q.size() != 0)
            $display("%0d expected reports never arrived", report_q.size());

        $display("Ran %0d rover events (%0d from the directed table) and checked %0d reports,",
                 items_sent, directed_items, reports_seen);
        $display("over %0d register settings with idle and stall patterns on both streams.",
                 NUM_PHASES + 2);
        if (mismatches == 0 && report_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
